[rtl/tsblp_pkg.sv]
// ----------------------------------------------------------------------------
// tsblp_pkg: shared types and constants for the build-log parser
// Holds the transaction structs, result kinds, error codes and the signature.
// ----------------------------------------------------------------------------
package tsblp_pkg;

	localparam int LINE_BYTES_DEF = 4096;
	localparam int SIG_LEN = 13;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	typedef enum logic [1:0] {
		PH_HEAD = 2'd0,
		PH_BODY = 2'd1,
		PH_DONE = 2'd2,
		PH_ERR = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		K_HEADER = 2'd0,
		K_RECORD = 2'd1,
		K_END = 2'd2,
		K_ERROR = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		E_NONE = 3'd0,
		E_SIG = 3'd1,
		E_VER = 3'd2,
		E_NUM = 3'd3,
		E_NOTAB = 3'd4,
		E_MISSING = 3'd5,
		E_TRAIL = 3'd6,
		E_LONG = 3'd7
	} err_t;

	typedef struct packed {
		logic [7:0] byte_in;
		logic end_of_file;
	} in_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] error_code;
		logic [31:0] line_number;
		logic [2:0] log_version;
		logic signed [31:0] start_time;
		logic signed [31:0] end_time;
		logic signed [63:0] mod_time;
		logic [11:0] path_start;
		logic [11:0] path_length;
		logic [63:0] hash_value;
	} out_t;

	// Signature byte by position
	function automatic logic [7:0] sig_byte(input logic [3:0] i);
		logic [7:0] b;
		case (i)
			4'd0: b = 8'h23;
			4'd1: b = 8'h20;
			4'd2: b = 8'h6E;
			4'd3: b = 8'h69;
			4'd4: b = 8'h6E;
			4'd5: b = 8'h6A;
			4'd6: b = 8'h61;
			4'd7: b = 8'h20;
			4'd8: b = 8'h6C;
			4'd9: b = 8'h6F;
			4'd10: b = 8'h67;
			4'd11: b = 8'h20;
			4'd12: b = 8'h76;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

[rtl/tsblp_out_buf.sv]
// ----------------------------------------------------------------------------
// tsblp_out_buf: two-entry result buffer
// Lets the parser keep taking bytes while a result waits to be taken.
// ----------------------------------------------------------------------------
module tsblp_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tsblp_pkg::out_t   push_data,
	output logic              space,
	output logic              out_valid,
	input  logic              out_ready,
	output tsblp_pkg::out_t   out_data
);

	tsblp_pkg::out_t mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic pop;

	assign pop = out_valid && out_ready;
	assign out_valid = cnt_q != 2'd0;
	assign out_data = mem_q[rd_ptr_q];
	// accept a transaction while a slot is free for its result
	assign space = cnt_q != 2'd2;

	// hold entries
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

[rtl/tab_separated_build_log_parser.sv]
// ----------------------------------------------------------------------------
// tab_separated_build_log_parser: byte-serial build-log line parser
// Checks the header line and parses tab-separated records one byte a cycle while the buffer has room.
// ----------------------------------------------------------------------------
// A result is written into the buffer as its byte is accepted and shows on out_valid in the cycle after.
// Throughput: one byte per cycle; ready drops only while two results wait.
// Each byte is handled by the parse logic between the state and result register.
// Reset returns the parse state to the header phase with line 1, sets mask_q to 31 and empties the buffer.
module tab_separated_build_log_parser #(
	parameter int LINE_BYTES = tsblp_pkg::LINE_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  tsblp_pkg::in_t   in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output tsblp_pkg::out_t  out_data,
	input  logic             cfg_we,
	input  logic [4:0]       cfg_data
);

	localparam int CW = $clog2(LINE_BYTES);

	tsblp_pkg::phase_t phase_q, phase_d;
	logic [3:0] hidx_q, hidx_d;
	logic [2:0] fidx_q, fidx_d;
	logic [CW-1:0] col_q, col_d;
	logic [63:0] acc_q, acc_d;
	logic neg_q, neg_d, seen_q, seen_d;
	logic [31:0] hstart_q, hstart_d, hend_q, hend_d;
	logic [63:0] hmt_q, hmt_d;
	logic [CW-1:0] hps_q, hps_d;
	logic [CW-1:0] hpl_q, hpl_d;
	logic [31:0] line_q, line_d;
	logic [2:0] ver_q, ver_d;
	logic [4:0] mask_q;

	logic fire, push, space, line_end;
	logic [7:0] c;
	tsblp_pkg::out_t res;

	// number datapath
	logic [3:0] dig;
	logic isdig, hex, fon;
	logic [63:0] lim, mul, nxt;
	logic ovf;
	logic [63:0] cval;
	logic [CW-1:0] plen;

	assign in_ready = space;
	assign fire = in_valid && in_ready;
	assign c = in_data.byte_in;
	assign line_end = in_data.end_of_file || c == tsblp_pkg::CH_LF;
	assign fon = fidx_q < 3'd5 && mask_q[fidx_q];
	assign hex = fidx_q == 3'd4;

	// decode digit
	always_comb begin
		isdig = 1'b1;
		dig = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) dig = 4'(c - 8'h30);
		else if (hex && c >= 8'h61 && c <= 8'h66) dig = 4'(c - 8'h57);
		else if (hex && c >= 8'h41 && c <= 8'h46) dig = 4'(c - 8'h37);
		else isdig = 1'b0;
	end

	// overflow test: compute acc*base+d with carry out
	always_comb begin
		logic [67:0] wide;
		if (fidx_q < 3'd2) lim = 64'h7FFF_FFFF;
		else if (fidx_q == 3'd2) lim = 64'h7FFF_FFFF_FFFF_FFFF;
		else lim = '1;
		if (neg_q && fidx_q < 3'd3) lim = lim + 64'd1;
		if (hex) wide = {acc_q, 4'h0} + {64'd0, dig};
		else wide = {3'b000, acc_q, 1'b0} + {1'b0, acc_q, 3'b000} + {64'd0, dig};
		mul = wide[63:0];
		ovf = (wide[67:64] != 4'd0) || (wide[63:0] > lim);
		nxt = mul;
	end

	assign cval = neg_q ? (64'd0 - acc_q) : acc_q;
	assign plen = col_q - hps_q;

	// next state and result
	always_comb begin
		logic [2:0] e;
		logic [2:0] fn;
		phase_d = phase_q; hidx_d = hidx_q; fidx_d = fidx_q; col_d = col_q;
		acc_d = acc_q; neg_d = neg_q; seen_d = seen_q;
		hstart_d = hstart_q; hend_d = hend_q; hmt_d = hmt_q; hps_d = hps_q;
		hpl_d = hpl_q;
		line_d = line_q; ver_d = ver_q;
		push = 1'b0;
		res = '0;
		res.line_number = line_q;
		res.log_version = ver_q;
		e = tsblp_pkg::E_NONE;
		fn = fidx_q + 3'd1;
		if (fire) begin
			unique case (phase_q)
				tsblp_pkg::PH_HEAD: begin
					if (hidx_q < 4'(tsblp_pkg::SIG_LEN)) begin
						if (line_end || c != tsblp_pkg::sig_byte(hidx_q)) e = tsblp_pkg::E_SIG;
						else hidx_d = hidx_q + 4'd1;
					end else if (hidx_q == 4'(tsblp_pkg::SIG_LEN)) begin
						if (line_end || c < 8'h35 || c > 8'h37) e = tsblp_pkg::E_VER;
						else begin
							ver_d = 3'(c - 8'h30);
							hidx_d = hidx_q + 4'd1;
						end
					end else if (!line_end) e = tsblp_pkg::E_VER;
					else begin
						push = 1'b1;
						res.kind = tsblp_pkg::K_HEADER;
						phase_d = tsblp_pkg::PH_BODY;
						if (line_q != '1) line_d = line_q + 32'd1;
						col_d = '0; fidx_d = '0; acc_d = '0; neg_d = 1'b0; seen_d = 1'b0;
					end
				end
				tsblp_pkg::PH_BODY: begin
					if (line_end && col_q == '0 && fidx_q == 3'd0) begin
						push = 1'b1;
						res.kind = tsblp_pkg::K_END;
						phase_d = tsblp_pkg::PH_DONE;
					end else if (!line_end && col_q >= CW'(LINE_BYTES - 1)) begin
						e = tsblp_pkg::E_LONG;
					end else if (line_end || c == tsblp_pkg::CH_TAB) begin
						// close the current field
						if (fidx_q != 3'd3 && fon && !seen_q) e = tsblp_pkg::E_NUM;
						else begin
							case (fidx_q)
								3'd0: hstart_d = fon ? cval[31:0] : '0;
								3'd1: hend_d = fon ? cval[31:0] : '0;
								3'd2: hmt_d = fon ? cval : '0;
								3'd3: begin
									// latch the path length, or drop the path when skipped
									if (fon) hpl_d = plen;
									else begin
										hps_d = '0;
										hpl_d = '0;
									end
								end
								default: ;
							endcase
							if (fn == 3'd3) hps_d = col_q + CW'(1);
							acc_d = '0; neg_d = 1'b0; seen_d = 1'b0;
							fidx_d = fn;
							if (line_end) begin
								if (fn < 3'd5)
									e = (mask_q[fn] && fn != 3'd3) ?
										tsblp_pkg::E_NUM : tsblp_pkg::E_MISSING;
								else begin
									push = 1'b1;
									res.kind = tsblp_pkg::K_RECORD;
									res.start_time = hstart_q;
									res.end_time = hend_q;
									res.mod_time = hmt_q;
									res.path_start = 12'(hps_q);
									res.path_length = 12'(hpl_q);
									res.hash_value = fon ? cval : '0;
									if (line_q != '1) line_d = line_q + 32'd1;
									col_d = '0; fidx_d = '0;
								end
							end else if (fn >= 3'd5) e = tsblp_pkg::E_TRAIL;
							else col_d = col_q + CW'(1);
						end
					end else begin
						// number byte
						if (fon && fidx_q != 3'd3) begin
							if (isdig) begin
								if (ovf) e = tsblp_pkg::E_NUM;
								else begin
									acc_d = nxt;
									seen_d = 1'b1;
								end
							end else if (!seen_q) begin
								if (!hex && c == tsblp_pkg::CH_MINUS && !neg_q) neg_d = 1'b1;
								else e = tsblp_pkg::E_NUM;
							end else e = tsblp_pkg::E_NOTAB;
						end
						if (e == tsblp_pkg::E_NONE) col_d = col_q + CW'(1);
					end
				end
				default: ;
			endcase
			if (e != tsblp_pkg::E_NONE) begin
				push = 1'b1;
				res = '0;
				res.kind = tsblp_pkg::K_ERROR;
				res.error_code = e;
				res.line_number = line_q;
				res.log_version = ver_q;
				phase_d = tsblp_pkg::PH_ERR;
			end
		end
	end

	// hold parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tsblp_pkg::PH_HEAD;
			hidx_q <= '0; fidx_q <= '0; col_q <= '0; acc_q <= '0;
			neg_q <= 1'b0; seen_q <= 1'b0;
			hstart_q <= '0; hend_q <= '0; hmt_q <= '0; hps_q <= '0; hpl_q <= '0;
			line_q <= 32'd1; ver_q <= '0;
			mask_q <= 5'd31;
		end else begin
			phase_q <= phase_d; hidx_q <= hidx_d; fidx_q <= fidx_d; col_q <= col_d;
			acc_q <= acc_d; neg_q <= neg_d; seen_q <= seen_d;
			hstart_q <= hstart_d; hend_q <= hend_d; hmt_q <= hmt_d; hps_q <= hps_d;
			hpl_q <= hpl_d;
			line_q <= line_d; ver_q <= ver_d;
			if (cfg_we) mask_q <= cfg_data;
		end
	end

	tsblp_out_buf u_buf (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(res), .space(space),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

endmodule
